/* rtl/core/state_space_scan_step_macros.svh */
// Assertion macros for the checker file of the scan step block.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef STATE_SPACE_SCAN_STEP_MACROS_SVH
`define STATE_SPACE_SCAN_STEP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSCAN_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scan step check failed");

// The consequent must hold from the cycle after the antecedent.
`define SSCAN_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scan step check failed");

`endif

/* rtl/core/sscan_pkg.sv */
// Package for the state-space scan step: widths, constants, controller types.
// Used by every module of the block but the RAM; depends on nothing.
`timescale 1ns / 1ps

package sscan_pkg;

    localparam int STATE_SIZE_DEF = 16;
    localparam int FRAC_BITS      = 12;
    localparam int IDX_W          = 4;
    localparam int COEF_W         = 16;
    localparam int H_W            = 24;
    localparam int SUM_W          = 32;
    localparam int PROD_W         = COEF_W + H_W;
    localparam int SHIFT_W        = PROD_W - FRAC_BITS;
    localparam int IN_FIELDS_W    = IDX_W + 3 * COEF_W;
    localparam int IN_TDATA_W     = ((IN_FIELDS_W + 7) / 8) * 8;

    localparam logic signed [H_W-1:0]   H_MAX = {1'b0, {(H_W-1){1'b1}}};
    localparam logic signed [H_W-1:0]   H_MIN = {1'b1, {(H_W-1){1'b0}}};
    localparam logic signed [SUM_W-1:0] S_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] S_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL1,
        ST_UPD,
        ST_MUL2,
        ST_SUM
    } state_t;

    typedef struct packed {
        logic accept;
        logic mul1;
        logic upd;
        logic mul2;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic item_last;
        logic out_blocked;
    } sts_t;

endpackage

/* rtl/core/sscan_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Stands alone; used for the hidden state store.
`timescale 1ns / 1ps

module sscan_ram #(
    parameter int WIDTH  = 24,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/sscan_ctrl.sv */
// Sequencer of the scan step: steps one beat through multiply, update,
// multiply and accumulate. Depends on sscan_pkg.
`timescale 1ns / 1ps

module sscan_ctrl
    import sscan_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;
    logic   done;

    assign done = !(sts.item_last && sts.out_blocked);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1: state_next = ST_UPD;
            ST_UPD:  state_next = ST_MUL2;
            ST_MUL2: state_next = ST_SUM;
            ST_SUM:
            begin
                if (done)
                begin
                    state_next = in_valid ? ST_MUL1 : ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: in_ready = 1'b1;
            ST_MUL1: cmd.mul1 = 1'b1;
            ST_UPD:  cmd.upd  = 1'b1;
            ST_MUL2: cmd.mul2 = 1'b1;
            ST_SUM:
            begin
                cmd.finish = done;
                in_ready   = done;
            end
            default: in_ready = 1'b0;
        endcase
        cmd.accept = in_ready && in_valid;
    end

endmodule

/* rtl/core/sscan_dpath.sv */
// Datapath of the scan step: hidden state RAM, two multipliers, saturation,
// step sum and output register. Depends on sscan_pkg and sscan_ram.
`timescale 1ns / 1ps

module sscan_dpath
    import sscan_pkg::*;
#(
    parameter int STATE_SIZE = STATE_SIZE_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    output sts_t                  sts,
    input  logic [IN_TDATA_W-1:0] in_data,
    input  logic                  in_first,
    input  logic                  in_last,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [SUM_W-1:0]      out_data
);

    localparam int AW = (STATE_SIZE > 1) ? $clog2(STATE_SIZE) : 1;

    logic [IDX_W-1:0]          in_idx;
    logic [AW-1:0]             in_addr;
    logic                      in_range;

    logic [AW-1:0]             addr_reg;
    logic                      range_reg;
    logic                      first_reg;
    logic                      last_reg;
    logic signed [COEF_W-1:0]  decay_reg;
    logic signed [COEF_W-1:0]  drive_reg;
    logic signed [COEF_W-1:0]  readout_reg;

    logic [STATE_SIZE-1:0]     valid_reg;
    logic [H_W-1:0]            ram_rdata;
    logic signed [H_W-1:0]     prev;

    logic signed [PROD_W-1:0]  p1_reg;
    logic signed [PROD_W-1:0]  p1_next;
    logic signed [H_W-1:0]     h_reg;
    logic signed [H_W-1:0]     h_next;
    logic signed [H_W+4:0]     h_wide;
    logic signed [PROD_W-1:0]  p2_reg;
    logic signed [PROD_W-1:0]  p2_next;

    logic signed [SUM_W-1:0]   sum_reg;
    logic signed [SUM_W-1:0]   sum_next;
    logic signed [SUM_W-1:0]   sum_sat;
    logic signed [SUM_W:0]     sum_wide;
    logic signed [SHIFT_W-1:0] addend;

    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [SUM_W-1:0]          out_data_reg;
    logic                      load_out;

    assign in_idx   = in_data[IDX_W-1:0];
    assign in_range = ({{(32-IDX_W){1'b0}}, in_idx} < 32'(STATE_SIZE));

    generate
        if (AW > IDX_W)
        begin : g_addr_wide
            assign in_addr = {{(AW-IDX_W){1'b0}}, in_idx};
        end
        else if (AW == IDX_W)
        begin : g_addr_same
            assign in_addr = in_idx;
        end
        else
        begin : g_addr_narrow
            assign in_addr = in_idx[AW-1:0];
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            addr_reg    <= in_addr;
            range_reg   <= in_range;
            first_reg   <= in_first;
            last_reg    <= in_last;
            decay_reg   <= in_data[IDX_W +: COEF_W];
            drive_reg   <= in_data[IDX_W + COEF_W +: COEF_W];
            readout_reg <= in_data[IDX_W + 2 * COEF_W +: COEF_W];
        end
        if (cmd.mul1)
        begin
            p1_reg <= p1_next;
        end
        if (cmd.upd)
        begin
            h_reg <= h_next;
        end
        if (cmd.mul2)
        begin
            p2_reg <= p2_next;
        end
        if (load_out)
        begin
            out_data_reg <= sum_sat;
        end
    end

    sscan_ram #(
        .WIDTH (H_W),
        .DEPTH (STATE_SIZE)
    ) u_hidden_ram (
        .clk   (clk),
        .we    (cmd.upd && range_reg),
        .waddr (addr_reg),
        .wdata (h_next),
        .re    (cmd.accept),
        .raddr (in_addr),
        .rdata (ram_rdata)
    );

    // An entry never written since reset reads as zero.
    assign prev    = (range_reg && !first_reg && valid_reg[addr_reg]) ?
                     $signed(ram_rdata) : '0;
    assign p1_next = decay_reg * prev;

    assign h_wide = {p1_reg[PROD_W-1], p1_reg[PROD_W-1:FRAC_BITS]}
                  + {{(H_W+5-COEF_W){drive_reg[COEF_W-1]}}, drive_reg};

    always_comb
    begin
        if (!h_wide[H_W+4] && (|h_wide[H_W+3:H_W-1]))
        begin
            h_next = H_MAX;
        end
        else if (h_wide[H_W+4] && !(&h_wide[H_W+3:H_W-1]))
        begin
            h_next = H_MIN;
        end
        else
        begin
            h_next = h_wide[H_W-1:0];
        end
    end

    assign p2_next = readout_reg * h_reg;
    assign addend  = range_reg ? p2_reg[PROD_W-1:FRAC_BITS] : '0;

    assign sum_wide = {sum_reg[SUM_W-1], sum_reg}
                    + {{(SUM_W+1-SHIFT_W){addend[SHIFT_W-1]}}, addend};

    always_comb
    begin
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
        begin
            sum_sat = sum_wide[SUM_W] ? S_MIN : S_MAX;
        end
        else
        begin
            sum_sat = sum_wide[SUM_W-1:0];
        end
    end

    assign load_out = cmd.finish && last_reg;

    always_comb
    begin
        sum_next = sum_reg;
        if (cmd.finish)
        begin
            sum_next = last_reg ? '0 : sum_sat;
        end
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.upd && range_reg)
            begin
                valid_reg[addr_reg] <= 1'b1;
            end
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign sts.item_last   = last_reg;
    assign sts.out_blocked = out_valid_reg && !out_ready;
    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;

endmodule

/* rtl/core/state_space_scan_step.sv */
// Top level of the state-space scan step: sequencer plus datapath.
// Depends on sscan_pkg, sscan_ctrl, sscan_dpath and sscan_ram.
//
// Each input beat carries one hidden-state element of one time step. The
// block updates that element, adds its readout product to the step sum, and
// on a beat with tlast set sends the saturated sum as one output beat and
// clears the sum. A set tuser bit treats the old element as zero.
// Accepting a beat starts the hidden RAM read. Then come the decay multiply,
// the update and write-back, the readout multiply, and the sum update, in
// whose cycle the next beat can be accepted, so a beat is not taken before
// the one ahead reaches its sum update; that of a tlast beat loads the output.
// The result sits in an output register, so the next beat is accepted while
// it waits. If the receiver stalls and another tlast beat completes, that
// beat holds in its last cycle until the output register frees.
// Reset marks the hidden state empty, so it reads as zero, and clears the step sum and the output valid flag.
`timescale 1ns / 1ps

module state_space_scan_step
    import sscan_pkg::*;
#(
    parameter int STATE_SIZE = STATE_SIZE_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // From bit 0: state_index[3:0], decay[15:0], drive[15:0], readout[15:0], zero pad.
    input  logic [IN_TDATA_W-1:0] s_axis_tdata,
    // first_step.
    input  logic                  s_axis_tuser,
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // From bit 0: scan_out[31:0].
    output logic [SUM_W-1:0]      m_axis_tdata
);

    cmd_t cmd;
    sts_t sts;

    sscan_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sscan_dpath #(
        .STATE_SIZE (STATE_SIZE)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (s_axis_tdata),
        .in_first  (s_axis_tuser),
        .in_last   (s_axis_tlast),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata)
    );

endmodule

/* rtl/core/sscan_chk.sv */
// Port-level checker for the scan step, bound to the top level.
// Depends on sscan_pkg and state_space_scan_step_macros.svh.
`timescale 1ns / 1ps
`include "state_space_scan_step_macros.svh"

module sscan_chk
    import sscan_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  s_axis_tlast,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [SUM_W-1:0]      m_axis_tdata
);

    logic in_beat;
    logic last_beat;

    assign in_beat   = rst_n && s_axis_tvalid && s_axis_tready;
    assign last_beat = in_beat && s_axis_tlast;

    // A stalled result beat stays put.
    `SSCAN_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // After a beat the block is not ready through the decay multiply, update and readout multiply.
    `SSCAN_ASSERT_IMP(a_busy_after_beat, in_beat, ##1 !s_axis_tready ##1 !s_axis_tready ##1 !s_axis_tready)

    // A fresh result always follows a tlast input beat.
    `SSCAN_ASSERT_IMP(a_out_origin, $rose(m_axis_tvalid), $past(last_beat, 5))

endmodule

bind state_space_scan_step sscan_chk u_chk (.*);
